FILE: src/hq_pkg.sv
// shared types and constants for the binary min-heap queue
// no dependencies; used by every module of the block by scoped names
package hq_pkg;

	// heap geometry
	localparam int CAPACITY = 64;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	// child index width, room for twice the slot index plus two
	localparam int XIDX_W   = IDX_W + 2;

	// fixed field widths
	localparam int ID_W     = 16;
	localparam int PRIO_W   = 32;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 7;

	// operation codes
	localparam logic OP_ADD  = 1'b0;
	localparam logic OP_POLL = 1'b1;

	// result status codes
	localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

	// one heap slot
	typedef struct packed {
		logic        [ID_W-1:0]   id;
		logic signed [PRIO_W-1:0] prio;
	} entry_t;

	// request from the sequencer to the heap memory
	typedef struct packed {
		logic             rd_en;
		logic [IDX_W-1:0] rd_addr;
		logic             wr_en;
		logic [IDX_W-1:0] wr_addr;
		entry_t           wr_data;
	} mem_req_t;

	// finished result handed to the output register
	typedef struct packed {
		entry_t               data;
		logic [STATUS_W-1:0]  status;
		logic [COUNT_W-1:0]   count;
	} result_t;

	// sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_UP_RD,
		ST_UP_CMP,
		ST_POLL_ROOT,
		ST_POLL_LAST,
		ST_DN_L,
		ST_DN_R,
		ST_DN_RC,
		ST_DN_C,
		ST_WRITE,
		ST_FIN
	} state_t;

endpackage

FILE: src/hq_mem.sv
// heap slot memory: one write port, one read port with registered read data
// depends on hq_pkg for the slot type and the request struct
module hq_mem (
	input  logic              clk,
	input  hq_pkg::mem_req_t  req,
	output hq_pkg::entry_t    rdata
);

	hq_pkg::entry_t store [hq_pkg::CAPACITY];

	// write port
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			store[req.wr_addr] <= req.wr_data;
		end
	end

	// registered read port, data holds until the next read
	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			rdata <= store[req.rd_addr];
		end
	end

endmodule

FILE: src/hq_cmp.sv
// shared signed priority comparator used by every sift step
// depends on hq_pkg for the priority width
module hq_cmp (
	input  logic signed [hq_pkg::PRIO_W-1:0] a,
	input  logic signed [hq_pkg::PRIO_W-1:0] b,
	output logic                             lt
);

	// strict signed less-than
	assign lt = (a < b);

endmodule

FILE: src/hq_ctrl.sv
// sift sequencer: holds the moving entry, the hole index and the heap size,
// drives the slot memory and the shared comparator; depends on hq_pkg
module hq_ctrl (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              in_op,
	input  hq_pkg::entry_t                    in_entry,
	output hq_pkg::mem_req_t                  mem_req,
	input  hq_pkg::entry_t                    mem_rdata,
	output logic signed [hq_pkg::PRIO_W-1:0]  cmp_a,
	output logic signed [hq_pkg::PRIO_W-1:0]  cmp_b,
	input  logic                              cmp_lt,
	output logic                              res_valid,
	input  logic                              res_ready,
	output hq_pkg::result_t                   res
);

	hq_pkg::state_t                    state_q, state_d;
	logic [hq_pkg::CNT_W-1:0]          size_q, size_d;
	logic [hq_pkg::IDX_W-1:0]          hole_q, hole_d;
	logic [hq_pkg::IDX_W-1:0]          pick_idx_q, pick_idx_d;
	hq_pkg::entry_t                    elem_q, elem_d;
	hq_pkg::entry_t                    pick_q, pick_d;
	hq_pkg::entry_t                    res_data_q, res_data_d;
	logic [hq_pkg::STATUS_W-1:0]       res_status_q, res_status_d;

	logic [hq_pkg::IDX_W-1:0]          parent_ix;
	logic [hq_pkg::XIDX_W-1:0]         left_ix;
	logic [hq_pkg::XIDX_W-1:0]         right_ix;
	logic [hq_pkg::XIDX_W-1:0]         size_x;
	logic                              has_left;
	logic                              has_right;

	// child and parent indices of the hole
	assign parent_ix = hq_pkg::IDX_W'((hole_q - hq_pkg::IDX_W'(1)) >> 1);
	assign left_ix   = hq_pkg::XIDX_W'({hole_q, 1'b1});
	assign right_ix  = hq_pkg::XIDX_W'({hole_q, 1'b0}) + hq_pkg::XIDX_W'(2);
	assign size_x    = hq_pkg::XIDX_W'(size_q);
	assign has_left  = (left_ix < size_x);
	assign has_right = (right_ix < size_x);

	// result seen by the output register
	assign res_valid  = (state_q == hq_pkg::ST_FIN);
	assign res.data   = res_data_q;
	assign res.status = res_status_q;
	assign res.count  = hq_pkg::COUNT_W'(size_q);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hq_pkg::ST_IDLE;
			size_q  <= '0;
		end else begin
			state_q <= state_d;
			size_q  <= size_d;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		hole_q       <= hole_d;
		pick_idx_q   <= pick_idx_d;
		elem_q       <= elem_d;
		pick_q       <= pick_d;
		res_data_q   <= res_data_d;
		res_status_q <= res_status_d;
	end

	// next state, memory requests and comparator operands
	always_comb begin
		state_d      = state_q;
		size_d       = size_q;
		hole_d       = hole_q;
		pick_idx_d   = pick_idx_q;
		elem_d       = elem_q;
		pick_d       = pick_q;
		res_data_d   = res_data_q;
		res_status_d = res_status_q;
		mem_req      = '0;
		cmp_a        = elem_q.prio;
		cmp_b        = mem_rdata.prio;
		in_ready     = 1'b0;

		case (state_q)
			hq_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					res_data_d   = '0;
					res_status_d = hq_pkg::STATUS_OK;
					if (in_op == hq_pkg::OP_ADD) begin
						if (size_q == hq_pkg::CNT_W'(hq_pkg::CAPACITY)) begin
							res_status_d = hq_pkg::STATUS_FULL;
							state_d      = hq_pkg::ST_FIN;
						end else begin
							elem_d = in_entry;
							hole_d = hq_pkg::IDX_W'(size_q);
							size_d = size_q + hq_pkg::CNT_W'(1);
							if (size_q == '0) begin
								state_d = hq_pkg::ST_WRITE;
							end else begin
								state_d = hq_pkg::ST_UP_RD;
							end
						end
					end else begin
						if (size_q == '0) begin
							res_status_d = hq_pkg::STATUS_EMPTY;
							state_d      = hq_pkg::ST_FIN;
						end else begin
							// fetch the root
							mem_req.rd_en   = 1'b1;
							mem_req.rd_addr = '0;
							size_d          = size_q - hq_pkg::CNT_W'(1);
							state_d         = hq_pkg::ST_POLL_ROOT;
						end
					end
				end
			end

			// sift up: fetch the parent of the hole
			hq_pkg::ST_UP_RD: begin
				mem_req.rd_en   = 1'b1;
				mem_req.rd_addr = parent_ix;
				state_d         = hq_pkg::ST_UP_CMP;
			end

			// parent moves down into the hole while it is strictly greater
			hq_pkg::ST_UP_CMP: begin
				cmp_a = elem_q.prio;
				cmp_b = mem_rdata.prio;
				if (cmp_lt) begin
					mem_req.wr_en   = 1'b1;
					mem_req.wr_addr = hole_q;
					mem_req.wr_data = mem_rdata;
					hole_d          = parent_ix;
					if (parent_ix == '0) begin
						state_d = hq_pkg::ST_WRITE;
					end else begin
						state_d = hq_pkg::ST_UP_RD;
					end
				end else begin
					state_d = hq_pkg::ST_WRITE;
				end
			end

			// root captured, fetch the last entry
			hq_pkg::ST_POLL_ROOT: begin
				res_data_d      = mem_rdata;
				mem_req.rd_en   = 1'b1;
				mem_req.rd_addr = hq_pkg::IDX_W'(size_q);
				state_d         = hq_pkg::ST_POLL_LAST;
			end

			// last entry becomes the moving entry, hole at the root
			hq_pkg::ST_POLL_LAST: begin
				elem_d = mem_rdata;
				hole_d = '0;
				if (size_q == '0) begin
					state_d = hq_pkg::ST_FIN;
				end else begin
					state_d = hq_pkg::ST_DN_L;
				end
			end

			// sift down: fetch the left child
			hq_pkg::ST_DN_L: begin
				if (has_left) begin
					mem_req.rd_en   = 1'b1;
					mem_req.rd_addr = hq_pkg::IDX_W'(left_ix);
					state_d         = hq_pkg::ST_DN_R;
				end else begin
					state_d = hq_pkg::ST_WRITE;
				end
			end

			// left child in hand, fetch the right child if present
			hq_pkg::ST_DN_R: begin
				pick_d     = mem_rdata;
				pick_idx_d = hq_pkg::IDX_W'(left_ix);
				if (has_right) begin
					mem_req.rd_en   = 1'b1;
					mem_req.rd_addr = hq_pkg::IDX_W'(right_ix);
					state_d         = hq_pkg::ST_DN_RC;
				end else begin
					state_d = hq_pkg::ST_DN_C;
				end
			end

			// right child wins only when strictly smaller
			hq_pkg::ST_DN_RC: begin
				cmp_a = mem_rdata.prio;
				cmp_b = pick_q.prio;
				if (cmp_lt) begin
					pick_d     = mem_rdata;
					pick_idx_d = hq_pkg::IDX_W'(right_ix);
				end
				state_d = hq_pkg::ST_DN_C;
			end

			// stop when strictly smaller than the chosen child, else move it up
			hq_pkg::ST_DN_C: begin
				cmp_a = elem_q.prio;
				cmp_b = pick_q.prio;
				if (cmp_lt) begin
					state_d = hq_pkg::ST_WRITE;
				end else begin
					mem_req.wr_en   = 1'b1;
					mem_req.wr_addr = hole_q;
					mem_req.wr_data = pick_q;
					hole_d          = pick_idx_q;
					state_d         = hq_pkg::ST_DN_L;
				end
			end

			// moving entry settles in the hole
			hq_pkg::ST_WRITE: begin
				mem_req.wr_en   = 1'b1;
				mem_req.wr_addr = hole_q;
				mem_req.wr_data = elem_q;
				state_d         = hq_pkg::ST_FIN;
			end

			// hand the result to the output register
			hq_pkg::ST_FIN: begin
				if (res_ready) begin
					state_d = hq_pkg::ST_IDLE;
				end
			end

			default: begin
				state_d = hq_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

FILE: src/binary_min_heap_queue.sv
// binary min-heap queue, one request at a time through a shared comparator.
// an add sifts up, reading and comparing one parent per step; a poll reads the root and
// the last entry, then sifts down, reading the left child and, if present, the right child
// per level; full/empty cases go straight to the result. a new request is taken only once
// the last result is handed on; the one read port and the one comparator serve all steps.
// reset clears the size and the output valid, not the slots.
module binary_min_heap_queue (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // entry_id[15:0], entry_priority[47:16]
	input  logic [0:0]  s_tuser,   // operation[0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // out_id[15:0], out_priority[47:16], entry_count[54:48]
	output logic [1:0]  m_tuser    // status[1:0]
);

	hq_pkg::entry_t                     in_entry;
	hq_pkg::mem_req_t                   mem_req;
	hq_pkg::entry_t                     mem_rdata;
	logic signed [hq_pkg::PRIO_W-1:0]   cmp_a;
	logic signed [hq_pkg::PRIO_W-1:0]   cmp_b;
	logic                               cmp_lt;
	logic                               res_valid;
	logic                               res_ready;
	hq_pkg::result_t                    res;
	logic                               out_valid_q;
	hq_pkg::result_t                    out_q;

	// unpack the incoming request
	assign in_entry.id   = s_tdata[15:0];
	assign in_entry.prio = s_tdata[47:16];

	hq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_op     (s_tuser[0]),
		.in_entry  (in_entry),
		.mem_req   (mem_req),
		.mem_rdata (mem_rdata),
		.cmp_a     (cmp_a),
		.cmp_b     (cmp_b),
		.cmp_lt    (cmp_lt),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	hq_mem u_mem (
		.clk   (clk),
		.req   (mem_req),
		.rdata (mem_rdata)
	);

	hq_cmp u_cmp (
		.a  (cmp_a),
		.b  (cmp_b),
		.lt (cmp_lt)
	);

	// output register, refilled as soon as it empties
	assign res_ready = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	// pack the outgoing result
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_q.count, out_q.data.prio, out_q.data.id};
	assign m_tuser  = out_q.status;

endmodule
